// ----- rtl/pld_pkg.sv -----
// Shared widths, types and reset values for the point-to-line distance block.
`default_nettype none
package pld_pkg;
    // Field and register formats
    localparam int ROT_FRAC_BITS  = 16;
    localparam int ROT_ENTRY_BITS = 18;
    localparam int ROW_BITS       = 3 * ROT_ENTRY_BITS;
    localparam int COORD_BITS     = 21;
    localparam int TRANS_BITS     = 3 * COORD_BITS;
    localparam int DIST_BITS      = 22;

    // Internal arithmetic widths
    localparam int PROD_BITS   = ROT_ENTRY_BITS + COORD_BITS;
    localparam int ACC_BITS    = PROD_BITS + 2;
    localparam int SHIFT_BITS  = ACC_BITS - ROT_FRAC_BITS;
    localparam int PT_BITS     = SHIFT_BITS + 1;
    localparam int DIFF_BITS   = PT_BITS + 1;
    localparam int EDGE_BITS   = COORD_BITS + 1;
    localparam int ESQ_BITS    = 2 * EDGE_BITS;
    localparam int LEN_BITS    = ESQ_BITS + 2;
    localparam int MPROD_BITS  = 2 * DIFF_BITS;
    localparam int MINOR_BITS  = MPROD_BITS + 1;
    localparam int LO_BITS     = 32;
    localparam int HI_BITS     = MINOR_BITS - LO_BITS;
    localparam int SQ_BITS     = 2 * MINOR_BITS;
    localparam int SUM_BITS    = SQ_BITS + 2;
    localparam int QW_BITS     = SUM_BITS + 2;
    localparam int RW_BITS     = LEN_BITS + DIST_BITS;

    // Register reset values: identity rotation, zero translation
    localparam logic [ROW_BITS-1:0] ROT_ONE = ROW_BITS'(1) << ROT_FRAC_BITS;
    localparam logic [ROW_BITS-1:0] ROW0_RESET = ROT_ONE;
    localparam logic [ROW_BITS-1:0] ROW1_RESET = ROT_ONE << ROT_ENTRY_BITS;
    localparam logic [ROW_BITS-1:0] ROW2_RESET = ROT_ONE << (2 * ROT_ENTRY_BITS);

    // Register indexes
    localparam logic [1:0] REG_ROW0  = 2'd0;
    localparam logic [1:0] REG_ROW1  = 2'd1;
    localparam logic [1:0] REG_ROW2  = 2'd2;
    localparam logic [1:0] REG_TRANS = 2'd3;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic [ESQ_BITS-1:0]          esq_t;
    typedef logic [ROW_BITS-1:0]          row_t;
endpackage
`default_nettype wire

// ----- rtl/pld_transform.sv -----
// Pose transform stages: rotate, floor, translate, form the offsets to A and B, and square the edge A-B.
`default_nettype none
module pld_transform (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire pld_pkg::coord_t  p [3],
    input  wire pld_pkg::coord_t  a [3],
    input  wire pld_pkg::coord_t  b [3],
    input  wire pld_pkg::row_t    rot [3],
    input  wire logic [pld_pkg::TRANS_BITS-1:0] trans,
    output logic                  out_valid,
    output pld_pkg::diff_t        u [3],
    output pld_pkg::diff_t        v [3],
    output pld_pkg::esq_t         esq [3]
);
    logic signed [pld_pkg::PROD_BITS-1:0] prod_reg [3][3];
    pld_pkg::coord_t a_reg [3];
    pld_pkg::coord_t b_reg [3];
    logic signed [pld_pkg::EDGE_BITS-1:0] e_reg [3];
    logic v1_reg, v2_reg;
    pld_pkg::diff_t u_reg [3];
    pld_pkg::diff_t w_reg [3];
    pld_pkg::esq_t  esq_reg [3];

    logic signed [pld_pkg::PROD_BITS-1:0] prod_next [3][3];
    logic signed [pld_pkg::EDGE_BITS-1:0] e_next [3];
    pld_pkg::diff_t u_next [3];
    pld_pkg::diff_t w_next [3];
    pld_pkg::esq_t  esq_next [3];

    // Rotation products and line edge
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                prod_next[i][j] = $signed(rot[i][pld_pkg::ROT_ENTRY_BITS*j +:
                                  pld_pkg::ROT_ENTRY_BITS]) * p[j];
            end
            e_next[i] = pld_pkg::EDGE_BITS'(a[i]) - pld_pkg::EDGE_BITS'(b[i]);
        end
    end

    // Sum, floor, translate and subtract the line points; square the line edge
    always_comb begin
        logic signed [pld_pkg::ACC_BITS-1:0]   acc;
        logic signed [pld_pkg::SHIFT_BITS-1:0] flr;
        logic signed [pld_pkg::PT_BITS-1:0]    pt;
        logic signed [pld_pkg::ESQ_BITS-1:0]   sq;
        for (int i = 0; i < 3; i++) begin
            acc = pld_pkg::ACC_BITS'(prod_reg[i][0]) + pld_pkg::ACC_BITS'(prod_reg[i][1])
                + pld_pkg::ACC_BITS'(prod_reg[i][2]);
            flr = $signed(acc[pld_pkg::ACC_BITS-1:pld_pkg::ROT_FRAC_BITS]);
            pt  = pld_pkg::PT_BITS'(flr) + pld_pkg::PT_BITS'($signed(
                  trans[pld_pkg::COORD_BITS*i +: pld_pkg::COORD_BITS]));
            u_next[i] = pld_pkg::DIFF_BITS'(pt) - pld_pkg::DIFF_BITS'(a_reg[i]);
            w_next[i] = pld_pkg::DIFF_BITS'(pt) - pld_pkg::DIFF_BITS'(b_reg[i]);
            sq = e_reg[i] * e_reg[i];
            esq_next[i] = pld_pkg::esq_t'(sq);
        end
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            a_reg    <= a;
            b_reg    <= b;
            e_reg    <= e_next;
            u_reg    <= u_next;
            w_reg    <= w_next;
            esq_reg  <= esq_next;
        end
    end

    assign out_valid = v2_reg;
    assign u   = u_reg;
    assign v   = w_reg;
    assign esq = esq_reg;
endmodule
`default_nettype wire

// ----- rtl/pld_cross.sv -----
// Cross product stages: minors, their squares split into partial products, and the sums.
`default_nettype none
module pld_cross (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire pld_pkg::diff_t  u [3],
    input  wire pld_pkg::diff_t  v [3],
    input  wire pld_pkg::esq_t   esq [3],
    output logic            out_valid,
    output logic [pld_pkg::SUM_BITS-1:0] s_sum,
    output logic [pld_pkg::LEN_BITS-1:0] l_sum
);
    localparam int MP = pld_pkg::MPROD_BITS;
    localparam int MN = pld_pkg::MINOR_BITS;
    localparam int LO = pld_pkg::LO_BITS;
    localparam int HI = pld_pkg::HI_BITS;
    localparam int SQ = pld_pkg::SQ_BITS;
    localparam int LN = pld_pkg::LEN_BITS;

    logic [4:0] v_reg;
    logic signed [MP-1:0] mp_reg [6];
    logic [MN-1:0]        mag_reg [3];
    logic [2*HI-1:0]      hh_reg [3];
    logic [HI+LO-1:0]     hl_reg [3];
    logic [2*LO-1:0]      ll_reg [3];
    logic [SQ-1:0]        sq_reg [3];
    logic [pld_pkg::SUM_BITS-1:0] s_reg;
    logic [LN-1:0] l3_reg, l4_reg, l5_reg, l6_reg, l7_reg;

    logic signed [MP-1:0] mp_next [6];
    logic [MN-1:0]        mag_next [3];
    logic [SQ-1:0]        sq_next [3];

    // Minor products
    always_comb begin
        mp_next[0] = u[0] * v[1];
        mp_next[1] = v[0] * u[1];
        mp_next[2] = u[0] * v[2];
        mp_next[3] = v[0] * u[2];
        mp_next[4] = u[1] * v[2];
        mp_next[5] = v[1] * u[2];
    end

    // Minor differences and magnitudes
    always_comb begin
        logic signed [MN-1:0] mnr;
        for (int i = 0; i < 3; i++) begin
            mnr = MN'(mp_reg[2*i]) - MN'(mp_reg[2*i+1]);
            mag_next[i] = mnr[MN-1] ? MN'(-mnr) : MN'(mnr);
        end
    end

    // Recombine the partial products of each square
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq_next[i] = (SQ'(hh_reg[i]) << (2 * LO)) + (SQ'(hl_reg[i]) << (LO + 1))
                       + SQ'(ll_reg[i]);
        end
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            mp_reg  <= mp_next;
            l3_reg  <= LN'(esq[0]) + LN'(esq[1]) + LN'(esq[2]);
            mag_reg <= mag_next;
            l4_reg  <= l3_reg;
            for (int i = 0; i < 3; i++) begin
                hh_reg[i] <= mag_reg[i][MN-1:LO] * mag_reg[i][MN-1:LO];
                hl_reg[i] <= mag_reg[i][MN-1:LO] * mag_reg[i][LO-1:0];
                ll_reg[i] <= mag_reg[i][LO-1:0] * mag_reg[i][LO-1:0];
            end
            l5_reg  <= l4_reg;
            sq_reg  <= sq_next;
            l6_reg  <= l5_reg;
            s_reg   <= pld_pkg::SUM_BITS'(sq_reg[0]) + pld_pkg::SUM_BITS'(sq_reg[1])
                     + pld_pkg::SUM_BITS'(sq_reg[2]);
            l7_reg  <= l6_reg;
        end
    end

    assign out_valid = v_reg[4];
    assign s_sum = s_reg;
    assign l_sum = l7_reg;
endmodule
`default_nettype wire

// ----- rtl/pld_sqrt.sv -----
// Bit-per-stage search for the largest d with d*d*L <= S, kept with running sums.
`default_nettype none
module pld_sqrt (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       en,
    input  wire logic       in_valid,
    input  wire logic [pld_pkg::SUM_BITS-1:0] s_sum,
    input  wire logic [pld_pkg::LEN_BITS-1:0] l_sum,
    output logic            out_valid,
    output logic [pld_pkg::DIST_BITS-1:0] distance,
    output logic            degenerate
);
    localparam int N  = pld_pkg::DIST_BITS;
    localparam int QW = pld_pkg::QW_BITS;
    localparam int RW = pld_pkg::RW_BITS;
    localparam int SW = pld_pkg::SUM_BITS;
    localparam int LW = pld_pkg::LEN_BITS;

    // Per stage: q holds d*d*L, r holds d*L
    logic          v_reg   [N];
    logic          deg_reg [N];
    logic [QW-1:0] q_reg   [N];
    logic [RW-1:0] r_reg   [N];
    logic [N-1:0]  d_reg   [N];
    logic [SW-1:0] s_reg   [N];
    logic [LW-1:0] l_reg   [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam int BIT = N - 1 - k;
        logic          v_prev, deg_prev;
        logic [QW-1:0] q_prev, cand;
        logic [RW-1:0] r_prev;
        logic [N-1:0]  d_prev;
        logic [SW-1:0] s_prev;
        logic [LW-1:0] l_prev;
        logic          fit;

        if (k == 0) begin : g_first
            assign v_prev   = in_valid;
            assign deg_prev = (l_sum == '0);
            assign q_prev   = '0;
            assign r_prev   = '0;
            assign d_prev   = '0;
            assign s_prev   = s_sum;
            assign l_prev   = l_sum;
        end else begin : g_next
            assign v_prev   = v_reg[k-1];
            assign deg_prev = deg_reg[k-1];
            assign q_prev   = q_reg[k-1];
            assign r_prev   = r_reg[k-1];
            assign d_prev   = d_reg[k-1];
            assign s_prev   = s_reg[k-1];
            assign l_prev   = l_reg[k-1];
        end

        // Trial: (d + 2^BIT)^2 * L from the running sums
        assign cand = q_prev + (QW'(r_prev) << (BIT + 1)) + (QW'(l_prev) << (2 * BIT));
        assign fit  = (cand <= QW'(s_prev));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                deg_reg[k] <= deg_prev;
                s_reg[k]   <= s_prev;
                l_reg[k]   <= l_prev;
                if (fit) begin
                    q_reg[k] <= cand;
                    r_reg[k] <= r_prev + (RW'(l_prev) << BIT);
                    d_reg[k] <= d_prev | (N'(1) << BIT);
                end else begin
                    q_reg[k] <= q_prev;
                    r_reg[k] <= r_prev;
                    d_reg[k] <= d_prev;
                end
            end
        end
    end

    // Coincident line points give zero distance
    assign out_valid  = v_reg[N-1];
    assign degenerate = deg_reg[N-1];
    assign distance   = deg_reg[N-1] ? '0 : d_reg[N-1];
endmodule
`default_nettype wire

// ----- rtl/point_to_line_distance.sv -----
// Top level: configuration registers, stream ports and the distance pipeline.
//
// Input items arrive on the s_ stream: a sensor point and two map points A and B,
// nine signed Q11.10 coordinates. Each item gives one result on the m_ stream:
// the distance from the posed point to line AB (unsigned Q12.10, floored,
// saturating) in m_tdata and a degenerate flag (A equals B, distance 0) in m_tuser.
// The pose (three rotation rows, translation) is written over the APB port at
// byte addresses 0, 8, 16 and 24; write it only while the pipeline is empty.
// The pipeline has two transform stages, five cross product stages and one
// stage per distance bit in the root search, the last of which is the output
// register. Throughput is one item per cycle while no result is held waiting.
// The whole pipeline advances together: when m_tready is low with a result
// waiting, s_tready drops and every stage holds; nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and loads the identity
// pose with zero translation.
`default_nettype none
module point_to_line_distance (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // point_x, point_y, point_z, line_a_x..z, line_b_x..z, 21 bits each, zero pad
    input  wire logic [191:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // distance [21:0], zero pad
    output logic [23:0]       m_tdata,
    // degenerate
    output logic [0:0]        m_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);
    localparam int CB = pld_pkg::COORD_BITS;

    pld_pkg::row_t rot_reg [3];
    logic [pld_pkg::TRANS_BITS-1:0] trans_reg;
    logic [1:0] reg_idx;
    logic       wr_en;
    logic       en;

    pld_pkg::coord_t p [3];
    pld_pkg::coord_t a [3];
    pld_pkg::coord_t b [3];
    pld_pkg::diff_t  u [3];
    pld_pkg::diff_t  v [3];
    pld_pkg::esq_t   esq [3];
    logic            t_valid, c_valid;
    logic [pld_pkg::SUM_BITS-1:0] s_sum;
    logic [pld_pkg::LEN_BITS-1:0] l_sum;
    logic [pld_pkg::DIST_BITS-1:0] distance;
    logic            degenerate;

    // Register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_reg[0] <= pld_pkg::ROW0_RESET;
            rot_reg[1] <= pld_pkg::ROW1_RESET;
            rot_reg[2] <= pld_pkg::ROW2_RESET;
            trans_reg  <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                pld_pkg::REG_ROW0:  rot_reg[0] <= pwdata[pld_pkg::ROW_BITS-1:0];
                pld_pkg::REG_ROW1:  rot_reg[1] <= pwdata[pld_pkg::ROW_BITS-1:0];
                pld_pkg::REG_ROW2:  rot_reg[2] <= pwdata[pld_pkg::ROW_BITS-1:0];
                pld_pkg::REG_TRANS: trans_reg  <= pwdata[pld_pkg::TRANS_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            pld_pkg::REG_ROW0:  prdata = 64'(rot_reg[0]);
            pld_pkg::REG_ROW1:  prdata = 64'(rot_reg[1]);
            pld_pkg::REG_ROW2:  prdata = 64'(rot_reg[2]);
            pld_pkg::REG_TRANS: prdata = 64'(trans_reg);
            default:            prdata = '0;
        endcase
    end

    // Unpack the input item
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p[i] = $signed(s_tdata[CB*i +: CB]);
            a[i] = $signed(s_tdata[CB*(3+i) +: CB]);
            b[i] = $signed(s_tdata[CB*(6+i) +: CB]);
        end
    end

    // Hold every stage while a result waits
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    pld_transform u_transform (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_tvalid),
        .p(p), .a(a), .b(b), .rot(rot_reg), .trans(trans_reg),
        .out_valid(t_valid), .u(u), .v(v), .esq(esq)
    );

    pld_cross u_cross (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(t_valid),
        .u(u), .v(v), .esq(esq),
        .out_valid(c_valid), .s_sum(s_sum), .l_sum(l_sum)
    );

    pld_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(c_valid),
        .s_sum(s_sum), .l_sum(l_sum),
        .out_valid(m_tvalid), .distance(distance), .degenerate(degenerate)
    );

    assign m_tdata = 24'(distance);
    assign m_tuser = degenerate;

`ifndef SYNTH
    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 24'd0)
        else $error("degenerate result with nonzero distance");
    a_ready_link: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready not tied to output stall");
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present after reset");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");
`endif
endmodule
`default_nettype wire
